// File: rtl/rhsv_pkg.sv
// Shared types, constants and helper functions for the rainbow LED frame generator.
// Holds the control word layout, the sequencer program and the fixed-divisor helpers.
// Depends on nothing; used by rtl/rainbow_hsv_led_frame_generator.sv.
package rhsv_pkg;

    localparam int LED_COUNT  = 16;
    localparam int EMIT_LIMIT = 16;
    localparam int EMIT_COUNT = (LED_COUNT > EMIT_LIMIT) ? EMIT_LIMIT : LED_COUNT;

    localparam int HUE_W   = 9;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 4;
    localparam int PROD_W  = 2 * CHAN_W;
    localparam int STEP_W  = 3;
    localparam int SECT_W  = 3;

    localparam logic [HUE_W-1:0]  HUE_RANGE = HUE_W'(360);
    localparam logic [CHAN_W-1:0] CHAN_MAX  = CHAN_W'(255);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(EMIT_COUNT - 1);

    // Configuration register indexes.
    localparam logic CFG_SATURATION = 1'b0;
    localparam logic CFG_BRIGHTNESS = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_TICK,
        COND_MORE_LEDS
    } cond_t;

    // One control word of the sequencer program.
    typedef struct packed {
        logic  take_item;
        logic  ld_hue;
        logic  ld_sector;
        logic  ld_mul1;
        logic  ld_div1;
        logic  ld_mul2;
        logic  ld_out;
        logic  adv_hue;
        cond_t cond;
        step_t target;
    } ctl_t;

    // Program steps.
    localparam step_t ST_WAIT   = 3'd0;
    localparam step_t ST_HUE    = 3'd1;
    localparam step_t ST_SECTOR = 3'd2;
    localparam step_t ST_MUL1   = 3'd3;
    localparam step_t ST_DIV1   = 3'd4;
    localparam step_t ST_MUL2   = 3'd5;
    localparam step_t ST_OUT    = 3'd6;
    localparam step_t ST_ADV    = 3'd7;

    // Read-only control store, one word per step.
    function automatic ctl_t ucode(input step_t step);
        ctl_t w;
        w = '{take_item: 1'b0, ld_hue: 1'b0, ld_sector: 1'b0, ld_mul1: 1'b0,
              ld_div1: 1'b0, ld_mul2: 1'b0, ld_out: 1'b0, adv_hue: 1'b0,
              cond: COND_NEVER, target: ST_WAIT};
        case (step)
            ST_WAIT:
            begin
                w.take_item = 1'b1;
                w.cond      = COND_NO_TICK;
                w.target    = ST_WAIT;
            end
            ST_HUE:    w.ld_hue    = 1'b1;
            ST_SECTOR: w.ld_sector = 1'b1;
            ST_MUL1:   w.ld_mul1   = 1'b1;
            ST_DIV1:   w.ld_div1   = 1'b1;
            ST_MUL2:   w.ld_mul2   = 1'b1;
            ST_OUT:
            begin
                w.ld_out = 1'b1;
                w.cond   = COND_MORE_LEDS;
                w.target = ST_HUE;
            end
            ST_ADV:
            begin
                w.adv_hue = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = ST_WAIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

    // Hue offset of an LED on the strip: idx*360/LED_COUNT, a small constant table.
    function automatic logic [HUE_W-1:0] hue_offset(input logic [IDX_W-1:0] idx);
        int unsigned prod;
        prod = 32'(idx) * 32'(HUE_RANGE);
        return HUE_W'(prod / LED_COUNT);
    endfunction

    // Truncating division by 255 for any product of two 8-bit values.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + (PROD_W+1)'(x >> CHAN_W) + (PROD_W+1)'(1);
        return sum[PROD_W-1:CHAN_W];
    endfunction

endpackage

// File: rtl/rainbow_hsv_led_frame_generator.sv
// Rainbow LED frame generator: top level with the microcoded sequencer and its datapath.
// Depends on rtl/rhsv_pkg.sv for types, the control store and the divide helpers.
// Each frame item with frame_tick high yields one RGB item per LED.

// Each accepted frame item with frame_tick high produces one color item per LED of the
// strip, LED 0 first, with last_led marking the final one; an item with frame_tick low
// is taken and produces nothing. LED i gets hue start + i*360/LED_COUNT (mod 360), turned
// into RGB by the six-sector integer HSV conversion with the saturation and brightness
// registers (both reset to 255, index 0 and 1). After a frame the start hue steps by one
// and wraps from 359 to 0. A small program in a read-only control store runs the
// datapath: six steps per LED (hue, sector, two multiply steps and two divide-by-255
// steps, the last one loading the output register) and one closing step that advances the
// start hue before the program returns to the wait step that accepts the item; in_ready is
// low from acceptance until then, and the output step stalls while the output register
// holds a color not yet taken (out_ready low). The output register lets the next LED be
// worked on while the previous color waits to be taken. Configuration must be written
// only while idle.
module rainbow_hsv_led_frame_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [rhsv_pkg::CHAN_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        frame_tick,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rhsv_pkg::IDX_W-1:0]  led_index,
    output logic [rhsv_pkg::CHAN_W-1:0] red,
    output logic [rhsv_pkg::CHAN_W-1:0] green,
    output logic [rhsv_pkg::CHAN_W-1:0] blue,
    output logic                        last_led
);

    // Control state.
    rhsv_pkg::step_t                step_reg, step_next;
    logic [rhsv_pkg::IDX_W-1:0]     led_reg;
    logic [rhsv_pkg::HUE_W-1:0]     start_hue_reg;
    logic [rhsv_pkg::CHAN_W-1:0]    sat_reg;
    logic [rhsv_pkg::CHAN_W-1:0]    bright_reg;
    logic                           out_valid_reg;

    // Datapath registers.
    logic [rhsv_pkg::HUE_W-1:0]     hue_reg;
    logic [rhsv_pkg::SECT_W-1:0]    sector_reg;
    logic [rhsv_pkg::CHAN_W-1:0]    f_reg;
    logic [rhsv_pkg::PROD_W-1:0]    m_sf_reg, m_sg_reg, m_p_reg;
    logic [rhsv_pkg::CHAN_W-1:0]    aq_reg, at_reg, p_reg;
    logic [rhsv_pkg::PROD_W-1:0]    m_q_reg, m_t_reg;
    logic [rhsv_pkg::IDX_W-1:0]     out_idx_reg;
    logic [rhsv_pkg::CHAN_W-1:0]    out_r_reg, out_g_reg, out_b_reg;
    logic                           out_last_reg;

    rhsv_pkg::ctl_t                 ctl;
    logic                           accept;
    logic                           out_free;
    logic                           stall;
    logic                           is_last;
    logic                           jump;

    logic [rhsv_pkg::HUE_W-1:0]     base;
    logic [rhsv_pkg::HUE_W:0]       hue_sum;
    logic [rhsv_pkg::HUE_W-1:0]     hue_wrapped;
    logic [rhsv_pkg::SECT_W-1:0]    sector;
    logic [rhsv_pkg::HUE_W-1:0]     sector_base;
    logic [5:0]                     rem;
    logic [9:0]                     rem17;
    logic [rhsv_pkg::CHAN_W-1:0]    q_val, t_val;
    logic [rhsv_pkg::CHAN_W-1:0]    r_sel, g_sel, b_sel;
    logic [rhsv_pkg::HUE_W-1:0]     hue_inc;

    assign ctl      = rhsv_pkg::ucode(step_reg);
    assign in_ready = ctl.take_item;
    assign accept   = in_valid && ctl.take_item;
    assign out_free = !out_valid_reg || out_ready;
    // The output step waits until the output register can take a new color.
    assign stall    = ctl.ld_out && !out_free;
    assign is_last  = (led_reg == rhsv_pkg::LAST_IDX);

    always_comb
    begin
        case (ctl.cond)
            rhsv_pkg::COND_NEVER:     jump = 1'b0;
            rhsv_pkg::COND_ALWAYS:    jump = 1'b1;
            rhsv_pkg::COND_NO_TICK:   jump = !(accept && frame_tick);
            rhsv_pkg::COND_MORE_LEDS: jump = !is_last;
            default:                  jump = 1'b1;
        endcase
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_reg + rhsv_pkg::step_t'(1);
        end
    end

    // Hue of the current LED, wrapped once into 0..359.
    always_comb
    begin
        base        = (start_hue_reg >= rhsv_pkg::HUE_RANGE) ? '0 : start_hue_reg;
        hue_sum     = {1'b0, base} + {1'b0, rhsv_pkg::hue_offset(led_reg)};
        hue_wrapped = (hue_sum >= {1'b0, rhsv_pkg::HUE_RANGE})
                      ? rhsv_pkg::HUE_W'(hue_sum - {1'b0, rhsv_pkg::HUE_RANGE})
                      : rhsv_pkg::HUE_W'(hue_sum);
        hue_inc     = (base == rhsv_pkg::HUE_RANGE - rhsv_pkg::HUE_W'(1))
                      ? '0 : base + rhsv_pkg::HUE_W'(1);
    end

    // Sector by a compare chain, remainder by subtracting the sector start.
    always_comb
    begin
        if (hue_reg < rhsv_pkg::HUE_W'(60))
        begin
            sector = 3'd0;
        end
        else if (hue_reg < rhsv_pkg::HUE_W'(120))
        begin
            sector = 3'd1;
        end
        else if (hue_reg < rhsv_pkg::HUE_W'(180))
        begin
            sector = 3'd2;
        end
        else if (hue_reg < rhsv_pkg::HUE_W'(240))
        begin
            sector = 3'd3;
        end
        else if (hue_reg < rhsv_pkg::HUE_W'(300))
        begin
            sector = 3'd4;
        end
        else
        begin
            sector = 3'd5;
        end
        case (sector)
            3'd0:    sector_base = rhsv_pkg::HUE_W'(0);
            3'd1:    sector_base = rhsv_pkg::HUE_W'(60);
            3'd2:    sector_base = rhsv_pkg::HUE_W'(120);
            3'd3:    sector_base = rhsv_pkg::HUE_W'(180);
            3'd4:    sector_base = rhsv_pkg::HUE_W'(240);
            default: sector_base = rhsv_pkg::HUE_W'(300);
        endcase
        rem   = 6'(hue_reg - sector_base);
        // rem*255/60 equals rem*17/4 exactly.
        rem17 = 10'(rem) * 10'd17;
    end

    // Final divides and the sector swizzle feeding the output register.
    always_comb
    begin
        q_val = rhsv_pkg::div255(m_q_reg);
        t_val = rhsv_pkg::div255(m_t_reg);
        case (sector_reg)
            3'd0:
            begin
                r_sel = bright_reg; g_sel = t_val;      b_sel = p_reg;
            end
            3'd1:
            begin
                r_sel = q_val;      g_sel = bright_reg; b_sel = p_reg;
            end
            3'd2:
            begin
                r_sel = p_reg;      g_sel = bright_reg; b_sel = t_val;
            end
            3'd3:
            begin
                r_sel = p_reg;      g_sel = q_val;      b_sel = bright_reg;
            end
            3'd4:
            begin
                r_sel = t_val;      g_sel = p_reg;      b_sel = bright_reg;
            end
            default:
            begin
                r_sel = bright_reg; g_sel = p_reg;      b_sel = q_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= rhsv_pkg::ST_WAIT;
            led_reg       <= '0;
            start_hue_reg <= '0;
            sat_reg       <= rhsv_pkg::CHAN_MAX;
            bright_reg    <= rhsv_pkg::CHAN_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_write)
            begin
                if (cfg_index == rhsv_pkg::CFG_SATURATION)
                begin
                    sat_reg <= cfg_data;
                end
                else
                begin
                    bright_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                led_reg <= '0;
            end
            else if (ctl.ld_out && !stall)
            begin
                led_reg <= led_reg + rhsv_pkg::IDX_W'(1);
            end
            if (ctl.adv_hue)
            begin
                start_hue_reg <= hue_inc;
            end
            if (ctl.ld_out && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_hue)
        begin
            hue_reg <= hue_wrapped;
        end
        if (ctl.ld_sector)
        begin
            sector_reg <= sector;
            f_reg      <= rhsv_pkg::CHAN_W'(rem17 >> 2);
        end
        if (ctl.ld_mul1)
        begin
            m_sf_reg <= rhsv_pkg::PROD_W'(sat_reg) * rhsv_pkg::PROD_W'(f_reg);
            m_sg_reg <= rhsv_pkg::PROD_W'(sat_reg)
                        * rhsv_pkg::PROD_W'(rhsv_pkg::CHAN_MAX - f_reg);
            m_p_reg  <= rhsv_pkg::PROD_W'(bright_reg)
                        * rhsv_pkg::PROD_W'(rhsv_pkg::CHAN_MAX - sat_reg);
        end
        if (ctl.ld_div1)
        begin
            aq_reg <= rhsv_pkg::CHAN_MAX - rhsv_pkg::div255(m_sf_reg);
            at_reg <= rhsv_pkg::CHAN_MAX - rhsv_pkg::div255(m_sg_reg);
            p_reg  <= rhsv_pkg::div255(m_p_reg);
        end
        if (ctl.ld_mul2)
        begin
            m_q_reg <= rhsv_pkg::PROD_W'(bright_reg) * rhsv_pkg::PROD_W'(aq_reg);
            m_t_reg <= rhsv_pkg::PROD_W'(bright_reg) * rhsv_pkg::PROD_W'(at_reg);
        end
        if (ctl.ld_out && !stall)
        begin
            out_idx_reg  <= led_reg;
            out_r_reg    <= r_sel;
            out_g_reg    <= g_sel;
            out_b_reg    <= b_sel;
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_index = out_idx_reg;
    assign red       = out_r_reg;
    assign green     = out_g_reg;
    assign blue      = out_b_reg;
    assign last_led  = out_last_reg;

endmodule
